@@ rtl/core/lzw_pkg.sv @@
`default_nettype none
package lzw_pkg;

    localparam int DICT_AW      = 13;
    localparam int DICT_ENTRIES = 1 << DICT_AW;
    localparam int CODE_W       = 13;
    localparam int NFC_W        = 14;
    localparam int CW_W         = 4;
    localparam int MAX_CW       = 13;
    localparam int MIN_CW       = 9;
    localparam int ACC_W        = 20;
    localparam int CNT_W        = 5;

    localparam logic [CODE_W-1:0]  CODE_CLEAR = 13'd256;
    localparam logic [CODE_W-1:0]  CODE_END   = 13'd257;
    localparam logic [NFC_W-1:0]   FIRST_FREE = 14'd258;
    localparam logic [CODE_W-1:0]  MARKER_RST = 13'd4096;
    localparam logic [CW_W-1:0]    INIT_W_RST = 4'd10;
    localparam logic [DICT_AW-1:0] HASH_MULT  = 13'h19B1;

    localparam logic CFG_BUMP_MARKER = 1'b0;
    localparam logic CFG_INIT_WIDTH  = 1'b1;

    typedef enum logic [2:0] {
        ST_SWEEP, ST_IDLE, ST_HASH, ST_READ, ST_CMP, ST_LOAD, ST_EMIT
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] prefix;
        logic [7:0]        sym;
        logic [CODE_W-1:0] code;
    } t_entry;

    typedef struct packed {
        logic [CODE_W-1:0] val;
        logic [CW_W-1:0]   w;
    } t_code;

    // Low address bits of the multiplicative hash of (prefix, byte).
    function automatic logic [DICT_AW-1:0] hash_idx(input logic [CODE_W-1:0] pre,
                                                   input logic [7:0] sym);
        logic [20:0]          key;
        logic [20:0]          mix;
        logic [2*DICT_AW-1:0] prod;
        key  = {pre, sym};
        mix  = key ^ (key >> 11);
        prod = mix[DICT_AW-1:0] * HASH_MULT;
        return prod[DICT_AW-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/lzw_ifs.sv @@
`default_nettype none
interface lzw_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    modport source (output valid, mode, data_byte, input ready);
    modport sink   (input valid, mode, data_byte, output ready);
endinterface

interface lzw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
    modport source (output valid, out_byte, run_last, stream_done, input ready);
    modport sink   (input valid, out_byte, run_last, stream_done, output ready);
endinterface

interface lzw_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lzw_dict.sv @@
`default_nettype none
module lzw_dict (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [lzw_pkg::DICT_AW-1:0] i_wr_addr,
    input  wire lzw_pkg::t_entry             i_wr_data,
    input  wire logic [lzw_pkg::DICT_AW-1:0] i_rd_addr,
    output lzw_pkg::t_entry                  o_rd_data
);
    lzw_pkg::t_entry r_mem [lzw_pkg::DICT_ENTRIES];
    lzw_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
endmodule
`default_nettype wire

@@ rtl/core/lzw_variable_width_compressor.sv @@
// Steps: a byte that opens a prefix is taken in IDLE with no further step; a byte with a prefix takes a hash
//   step, then a read and a compare per probed slot, and returns to IDLE on a hit.
// A new pair adds a load step per queued code (up to 3), an emit step per output byte and a
//   closing emit step; an output stall holds the emit step until the byte can be pushed.
// Throughput: one request at a time, set by the probe loop and the one-code-at-a-time packer.
// Reset, a full-dictionary clear and every finish run a sweep over all 8192 entries; no request is taken.
`default_nettype none
module lzw_variable_width_compressor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    lzw_in_if.sink          i_in,
    lzw_out_if.source       o_out,
    lzw_cfg_if.sink         i_cfg
);
    lzw_pkg::t_state r_state, n_state;

    // configuration
    logic [lzw_pkg::CODE_W-1:0] r_marker;
    logic [lzw_pkg::CW_W-1:0]   r_init_w;

    // compressor state
    logic [lzw_pkg::CODE_W-1:0]  r_prefix, n_prefix;
    logic                        r_present, n_present;
    logic [lzw_pkg::NFC_W-1:0]   r_nfc, n_nfc;
    logic [lzw_pkg::CW_W-1:0]    r_cw, n_cw;
    logic [7:0]                  r_byte, n_byte;
    logic [lzw_pkg::DICT_AW-1:0] r_idx, n_idx;
    logic [lzw_pkg::DICT_AW-1:0] r_sw, n_sw;
    logic                        r_pad, n_pad;
    logic                        r_clr, n_clr;

    // code queue feeding the packer
    lzw_pkg::t_code r_q [3];
    lzw_pkg::t_code n_q [3];
    logic [1:0]     r_qn, n_qn;

    // bit packer
    logic [lzw_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [lzw_pkg::CNT_W-1:0] r_cnt, n_cnt;

    // output register
    logic       r_ov, n_ov;
    logic [7:0] r_ob, n_ob;
    logic       r_ol, n_ol;
    logic       r_od, n_od;

    // dictionary port
    logic                        dict_we;
    logic [lzw_pkg::DICT_AW-1:0] dict_wa;
    lzw_pkg::t_entry             dict_wd;
    lzw_pkg::t_entry             dict_rd;

    logic [lzw_pkg::CW_W-1:0]  start_w;
    logic                      in_acc;
    logic                      can_push;
    logic                      hit;
    logic                      grow;
    logic [lzw_pkg::CNT_W-1:0] cnt_m8;
    logic [lzw_pkg::ACC_W-1:0] load_mask;
    logic [lzw_pkg::ACC_W-1:0] emit_word;

    lzw_dict u_dict (
        .i_clk     (i_clk),
        .i_we      (dict_we),
        .i_wr_addr (dict_wa),
        .i_wr_data (dict_wd),
        .i_rd_addr (r_idx),
        .o_rd_data (dict_rd)
    );

    // clamp the programmed start width to the legal range
    always_comb begin
        if (r_init_w < lzw_pkg::CW_W'(lzw_pkg::MIN_CW)) begin
            start_w = lzw_pkg::CW_W'(lzw_pkg::MIN_CW);
        end else if (r_init_w > lzw_pkg::CW_W'(lzw_pkg::MAX_CW)) begin
            start_w = lzw_pkg::CW_W'(lzw_pkg::MAX_CW);
        end else begin
            start_w = r_init_w;
        end
    end

    assign i_in.ready  = (r_state == lzw_pkg::ST_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign can_push    = !r_ov || o_out.ready;

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_ob;
    assign o_out.run_last    = r_ol;
    assign o_out.stream_done = r_od;

    // the shared compare: does the slot hold the current pair
    assign hit  = dict_rd.valid && (dict_rd.prefix == r_prefix) && (dict_rd.sym == r_byte);
    assign grow = ((15'(r_nfc) + 15'd1) == (15'd1 << r_cw)) &&
                  (r_cw < lzw_pkg::CW_W'(lzw_pkg::MAX_CW));
    assign cnt_m8    = r_cnt - lzw_pkg::CNT_W'(8);
    assign load_mask = (lzw_pkg::ACC_W'(1) << r_q[0].w) - lzw_pkg::ACC_W'(1);
    assign emit_word = r_acc >> cnt_m8;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lzw_pkg::ST_SWEEP: begin
                if (&r_sw) n_state = lzw_pkg::ST_IDLE;
            end
            lzw_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.mode) n_state = lzw_pkg::ST_LOAD;
                    else if (r_present) n_state = lzw_pkg::ST_HASH;
                end
            end
            lzw_pkg::ST_HASH: n_state = lzw_pkg::ST_READ;
            lzw_pkg::ST_READ: n_state = lzw_pkg::ST_CMP;
            lzw_pkg::ST_CMP: begin
                if (hit) n_state = lzw_pkg::ST_IDLE;
                else if (!dict_rd.valid) n_state = lzw_pkg::ST_LOAD;
                else n_state = lzw_pkg::ST_READ;
            end
            lzw_pkg::ST_LOAD: n_state = lzw_pkg::ST_EMIT;
            lzw_pkg::ST_EMIT: begin
                if (r_cnt < lzw_pkg::CNT_W'(8)) begin
                    if (r_qn != 2'd0) n_state = lzw_pkg::ST_LOAD;
                    else if (r_pad && r_cnt != '0) n_state = lzw_pkg::ST_EMIT;
                    else if (r_pad || r_clr) n_state = lzw_pkg::ST_SWEEP;
                    else n_state = lzw_pkg::ST_IDLE;
                end
            end
            default: n_state = lzw_pkg::ST_SWEEP;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_prefix  = r_prefix;
        n_present = r_present;
        n_nfc     = r_nfc;
        n_cw      = r_cw;
        n_byte    = r_byte;
        n_idx     = r_idx;
        n_sw      = r_sw;
        n_pad     = r_pad;
        n_clr     = r_clr;
        n_q       = r_q;
        n_qn      = r_qn;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_ov      = r_ov && !o_out.ready;
        n_ob      = r_ob;
        n_ol      = r_ol;
        n_od      = r_od;
        dict_we   = 1'b0;
        dict_wa   = r_idx;
        dict_wd   = '{valid: 1'b1, prefix: r_prefix, sym: r_byte,
                      code: r_nfc[lzw_pkg::CODE_W-1:0]};
        case (r_state)
            lzw_pkg::ST_SWEEP: begin
                dict_we = 1'b1;
                dict_wa = r_sw;
                dict_wd = '0;
                n_sw    = r_sw + lzw_pkg::DICT_AW'(1);
                n_clr   = 1'b0;
            end
            lzw_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_byte = i_in.data_byte;
                    n_clr  = 1'b0;
                    if (i_in.mode) begin
                        // finish: flush the prefix, then the end code, then pad
                        n_pad = 1'b1;
                        if (r_present) begin
                            n_q[0] = '{val: r_prefix, w: r_cw};
                            n_q[1] = '{val: lzw_pkg::CODE_END, w: r_cw};
                            n_qn   = 2'd2;
                        end else begin
                            n_q[0] = '{val: lzw_pkg::CODE_END, w: r_cw};
                            n_qn   = 2'd1;
                        end
                    end else if (!r_present) begin
                        n_prefix  = {5'd0, i_in.data_byte};
                        n_present = 1'b1;
                    end
                end
            end
            lzw_pkg::ST_HASH: begin
                n_idx = lzw_pkg::hash_idx(r_prefix, r_byte);
            end
            lzw_pkg::ST_CMP: begin
                if (hit) begin
                    n_prefix = dict_rd.code;
                end else if (!dict_rd.valid) begin
                    n_q[0] = '{val: r_prefix, w: r_cw};
                    if (r_nfc < lzw_pkg::NFC_W'(lzw_pkg::DICT_ENTRIES)) begin
                        if (grow) begin
                            n_q[1] = '{val: r_marker, w: r_cw};
                            n_qn   = 2'd2;
                            n_cw   = r_cw + lzw_pkg::CW_W'(1);
                        end else begin
                            n_qn = 2'd1;
                        end
                        dict_we = 1'b1;
                        n_nfc   = r_nfc + lzw_pkg::NFC_W'(1);
                    end else begin
                        // dictionary full: clear code, marker at start width
                        n_q[1] = '{val: lzw_pkg::CODE_CLEAR, w: r_cw};
                        n_q[2] = '{val: r_marker, w: start_w};
                        n_qn   = 2'd3;
                        n_cw   = start_w;
                        n_nfc  = lzw_pkg::FIRST_FREE;
                        n_clr  = 1'b1;
                    end
                    n_prefix = {5'd0, r_byte};
                end else begin
                    n_idx = r_idx + lzw_pkg::DICT_AW'(1);
                end
            end
            lzw_pkg::ST_LOAD: begin
                n_acc  = (r_acc << r_q[0].w) |
                         (lzw_pkg::ACC_W'(r_q[0].val) & load_mask);
                n_cnt  = r_cnt + lzw_pkg::CNT_W'(r_q[0].w);
                n_q[0] = r_q[1];
                n_q[1] = r_q[2];
                n_qn   = r_qn - 2'd1;
            end
            lzw_pkg::ST_EMIT: begin
                if (r_cnt >= lzw_pkg::CNT_W'(8)) begin
                    if (can_push) begin
                        n_ov  = 1'b1;
                        n_ob  = emit_word[7:0];
                        n_ol  = (r_qn == 2'd0) &&
                                (cnt_m8 == '0 || (cnt_m8 < lzw_pkg::CNT_W'(8) && !r_pad));
                        n_od  = r_pad && (r_qn == 2'd0) && (cnt_m8 == '0);
                        n_cnt = cnt_m8;
                    end
                end else if (r_qn == 2'd0) begin
                    if (r_pad && r_cnt != '0) begin
                        if (can_push) begin
                            n_ov  = 1'b1;
                            n_ob  = 8'(r_acc << (lzw_pkg::CNT_W'(8) - r_cnt));
                            n_ol  = 1'b1;
                            n_od  = 1'b1;
                            n_cnt = '0;
                        end
                    end else if (r_pad) begin
                        // stream closed: back to the reset state of the coder
                        n_pad     = 1'b0;
                        n_prefix  = '0;
                        n_present = 1'b0;
                        n_nfc     = lzw_pkg::FIRST_FREE;
                        n_cw      = start_w;
                        n_acc     = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lzw_pkg::ST_SWEEP;
            r_marker  <= lzw_pkg::MARKER_RST;
            r_init_w  <= lzw_pkg::INIT_W_RST;
            r_prefix  <= '0;
            r_present <= 1'b0;
            r_nfc     <= lzw_pkg::FIRST_FREE;
            r_cw      <= lzw_pkg::INIT_W_RST;
            r_sw      <= '0;
            r_pad     <= 1'b0;
            r_clr     <= 1'b0;
            r_qn      <= '0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prefix  <= n_prefix;
            r_present <= n_present;
            r_nfc     <= n_nfc;
            r_cw      <= n_cw;
            r_sw      <= n_sw;
            r_pad     <= n_pad;
            r_clr     <= n_clr;
            r_qn      <= n_qn;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_ov      <= n_ov;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    lzw_pkg::CFG_BUMP_MARKER: r_marker <= i_cfg.data;
                    lzw_pkg::CFG_INIT_WIDTH:  r_init_w <= i_cfg.data[lzw_pkg::CW_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_idx  <= n_idx;
        r_q    <= n_q;
        r_ob   <= n_ob;
        r_ol   <= n_ol;
        r_od   <= n_od;
    end

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_od) |-> r_ol)
        else $error("stream end byte not flagged as last of its request");
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzw_pkg::ST_IDLE) |-> (r_cnt < lzw_pkg::CNT_W'(8) && r_qn == 2'd0))
        else $error("idle with whole bytes or codes still pending");
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode) |=> (r_state == lzw_pkg::ST_LOAD))
        else $error("finish request did not start the flush");
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cw >= lzw_pkg::CW_W'(lzw_pkg::MIN_CW) && r_cw <= lzw_pkg::CW_W'(lzw_pkg::MAX_CW)))
        else $error("code width out of range");
endmodule
`default_nettype wire

@@ bench/lzw_bench_pkg.sv @@
package lzw_bench_pkg;

    // Request kinds on the input channel.
    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

endpackage

@@ bench/lzw_stream_checker.sv @@
module lzw_stream_checker
    import lzw_pkg::*;
    import lzw_bench_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lzw_in_if    in_ch,
    lzw_out_if   out_ch,
    lzw_cfg_if   cfg_ch,
    output int   o_errors,
    output int   o_pending,
    output int   o_bytes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
    } t_packed_byte;

    t_packed_byte      packed_q[$];
    logic [CODE_W-1:0] code_of_pair[logic [20:0]];
    logic [CODE_W-1:0] cur_prefix;
    logic              has_prefix;
    int unsigned       free_code;
    int unsigned       width;
    longint unsigned   bit_acc;
    int unsigned       bit_cnt;
    logic [12:0]       marker;
    logic [3:0]        init_w;

    function automatic int unsigned clamped_width(logic [3:0] w);
        if (w < MIN_CW) return MIN_CW;
        if (w > MAX_CW) return MAX_CW;
        return w;
    endfunction

    // Append one code MSB first; release every full byte.
    task automatic pack_code(int unsigned value, int unsigned w);
        t_packed_byte b;
        bit_acc = (bit_acc << w) | (value & ((1 << w) - 1));
        bit_cnt += w;
        while (bit_cnt >= 8) begin
            b.out_byte    = 8'(bit_acc >> (bit_cnt - 8));
            b.run_last    = 1'b0;
            b.stream_done = 1'b0;
            packed_q.push_back(b);
            bit_cnt -= 8;
            bit_acc &= (64'd1 << bit_cnt) - 1;
        end
    endtask

    task automatic restart_dict();
        code_of_pair.delete();
        free_code = FIRST_FREE;
    endtask

    task automatic compress_request(logic mode, logic [7:0] sym);
        int           before_n;
        t_packed_byte b;
        logic [20:0]  key;
        before_n = packed_q.size();
        if (mode == MODE_DATA) begin
            key = {cur_prefix, sym};
            if (!has_prefix) begin
                cur_prefix = sym;
                has_prefix = 1'b1;
            end else if (code_of_pair.exists(key)) begin
                cur_prefix = code_of_pair[key];
            end else begin
                pack_code(cur_prefix, width);
                if (free_code < DICT_ENTRIES) begin
                    // Widen before the next code would no longer fit.
                    if (free_code + 1 == (1 << width) && width < MAX_CW) begin
                        pack_code(marker, width);
                        width++;
                    end
                    code_of_pair[key] = CODE_W'(free_code);
                    free_code++;
                end else begin
                    // Full: clear, fall back to the start width, mark it.
                    pack_code(CODE_CLEAR, width);
                    width = clamped_width(init_w);
                    pack_code(marker, width);
                    restart_dict();
                end
                cur_prefix = sym;
            end
            if (packed_q.size() > before_n)
                packed_q[packed_q.size()-1].run_last = 1'b1;
        end else begin
            if (has_prefix) pack_code(cur_prefix, width);
            pack_code(CODE_END, width);
            if (bit_cnt > 0) begin
                b.out_byte    = 8'(bit_acc << (8 - bit_cnt));
                b.run_last    = 1'b0;
                b.stream_done = 1'b0;
                packed_q.push_back(b);
            end
            packed_q[packed_q.size()-1].run_last    = 1'b1;
            packed_q[packed_q.size()-1].stream_done = 1'b1;
            bit_acc    = 0;
            bit_cnt    = 0;
            cur_prefix = '0;
            has_prefix = 1'b0;
            restart_dict();
            width = clamped_width(init_w);
        end
    endtask

    always @(posedge i_clk) begin
        t_packed_byte exp_b;
        if (!i_rst_n) begin
            packed_q.delete();
            marker     = MARKER_RST;
            init_w     = INIT_W_RST;
            restart_dict();
            cur_prefix = '0;
            has_prefix = 1'b0;
            width      = clamped_width(init_w);
            bit_acc    = 0;
            bit_cnt    = 0;
            o_errors   = 0;
            o_bytes    = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == CFG_BUMP_MARKER) marker = cfg_ch.data;
                else if (cfg_ch.index == CFG_INIT_WIDTH) init_w = cfg_ch.data[3:0];
            end
            if (in_ch.valid && in_ch.ready)
                compress_request(in_ch.mode, in_ch.data_byte);
            if (out_ch.valid && out_ch.ready) begin
                o_bytes++;
                if (packed_q.size() == 0) begin
                    $display("%0t: unexpected byte %h last=%b done=%b", $time,
                             out_ch.out_byte, out_ch.run_last, out_ch.stream_done);
                    o_errors++;
                end else begin
                    exp_b = packed_q.pop_front();
                    if (out_ch.out_byte !== exp_b.out_byte ||
                        out_ch.run_last !== exp_b.run_last ||
                        out_ch.stream_done !== exp_b.stream_done) begin
                        $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                                 exp_b.out_byte, exp_b.run_last, exp_b.stream_done,
                                 out_ch.out_byte, out_ch.run_last, out_ch.stream_done);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = packed_q.size();
    end

endmodule

@@ bench/testbench.sv @@
module testbench;
    import lzw_pkg::*;
    import lzw_bench_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   bytes_seen;
    int   cycles = 0;
    int   requests_sent;
    int   streams_closed;
    bit   idle_on;
    bit   stall_on;

    lzw_in_if  in_ch();
    lzw_out_if out_ch();
    lzw_cfg_if cfg_ch();

    lzw_variable_width_compressor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lzw_stream_checker checker_u (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_bytes   (bytes_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output backpressure: alternate ready runs and stalls, all at the falling edge.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            int run;
            int stall;
            run   = $urandom_range(1, 12);
            stall = stall_on ? gap_len() : 0;
            repeat (run) begin
                @(negedge i_clk);
                out_ch.ready = 1'b1;
            end
            repeat (stall) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
            end
        end
    end

    // Send one request; hold valid until accepted, then drop it only if a gap follows.
    task automatic send_request(logic mode, logic [7:0] sym);
        int gap;
        @(negedge i_clk);
        in_ch.valid     = 1'b1;
        in_ch.mode      = mode;
        in_ch.data_byte = sym;
        do @(posedge i_clk); while (!in_ch.ready);
        requests_sent++;
        if (mode == MODE_FINISH) streams_closed++;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid     = 1'b0;
            in_ch.data_byte = 8'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic park_input();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // Drain, let a byte with no output settle, then write one register.
    task automatic write_reg(logic index, logic [12:0] value);
        park_input();
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Random stream closed by a finish request; a small alphabet builds long matches.
    task automatic random_stream(int len, int alphabet);
        int k;
        for (k = 0; k < len; k++)
            send_request(MODE_DATA, (alphabet >= 256) ? 8'($urandom)
                                                      : 8'($urandom_range(0, alphabet - 1)));
        send_request(MODE_FINISH, 8'($urandom));
    endtask

    logic [12:0] marker_set[7] = '{13'd0, 13'd8191, 13'd4096, 13'd5555,
                                   13'd1234, 13'd77, 13'h0AAA};
    logic [3:0]  width_set[7]  = '{4'd9, 4'd13, 4'd10, 4'd0, 4'd15, 4'd11, 4'd12};

    initial begin
        int p;
        int s;
        requests_sent  = 0;
        streams_closed = 0;
        idle_on        = 1'b0;
        stall_on       = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_DATA;
        in_ch.data_byte = 8'd0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_BUMP_MARKER;
        cfg_ch.data    = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: finish on an empty stream, zero and all-ones bytes, repeats.
        send_request(MODE_FINISH, 8'hFF);
        send_request(MODE_DATA, 8'h00);
        send_request(MODE_FINISH, 8'h00);
        send_request(MODE_DATA, 8'h00);
        send_request(MODE_DATA, 8'h00);
        send_request(MODE_DATA, 8'h00);
        send_request(MODE_DATA, 8'h00);
        send_request(MODE_DATA, 8'hFF);
        send_request(MODE_DATA, 8'hFF);
        send_request(MODE_DATA, 8'hFF);
        send_request(MODE_DATA, 8'h55);
        send_request(MODE_DATA, 8'hAA);
        send_request(MODE_DATA, 8'h00);
        send_request(MODE_DATA, 8'h00);
        send_request(MODE_FINISH, 8'h00);

        // Sweep the settings, extremes and out-of-range widths among them.
        idle_on  = 1'b1;
        stall_on = 1'b1;
        for (p = 0; p < 7; p++) begin
            write_reg(CFG_BUMP_MARKER, marker_set[p]);
            write_reg(CFG_INIT_WIDTH, {9'd0, width_set[p]});
            idle_on  = (p != 2);
            stall_on = (p != 3);
            for (s = 0; s < 3; s++)
                random_stream($urandom_range(0, 8), ($urandom_range(0, 2) == 0) ? 256 : 4);
        end

        // Longer streams at the narrowest width: mostly new pairs, then long matches.
        write_reg(CFG_BUMP_MARKER, 13'($urandom));
        write_reg(CFG_INIT_WIDTH, 13'(MIN_CW));
        idle_on  = 1'b0;
        stall_on = 1'b1;
        random_stream(60, 256);
        random_stream(20, 3);

        park_input();
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Covered %0d requests in %0d streams, %0d output bytes checked",
                 requests_sent, streams_closed, bytes_seen);
        $display("Settings: 7 marker/width pairs, then two longer streams at the narrowest width");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lzw_pkg.sv
rtl/core/lzw_ifs.sv
rtl/core/lzw_dict.sv
rtl/core/lzw_variable_width_compressor.sv
bench/lzw_bench_pkg.sv
bench/lzw_stream_checker.sv
bench/testbench.sv
